// ----- design/sdcl_pkg.sv -----
// Shared types, constants and the CRC7 step for the SD CMD-line engine.
package sdcl_pkg;

  // Default number of card clocks to wait for a response start bit.
  localparam int START_WAIT_LIMIT_DEF = 32;

  localparam int BIT_W = 7;

  // Engine phases.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_PRE    = 3'd1;
  localparam logic [2:0] PH_TX     = 3'd2;
  localparam logic [2:0] PH_WAIT   = 3'd3;
  localparam logic [2:0] PH_RXIDX  = 3'd4;
  localparam logic [2:0] PH_RXDATA = 3'd5;
  localparam logic [2:0] PH_RXCRC  = 3'd6;

  // Item modes.
  localparam logic MODE_REQ  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Response kinds.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  // Start and transmission bits that precede the command index.
  localparam logic [1:0] CMD_PREFIX = 2'b01;

  localparam logic [BIT_W-1:0] TX_FIELD_BITS = 7'd40;
  localparam logic [BIT_W-1:0] TX_CRC_LAST   = 7'd46;
  localparam logic [BIT_W-1:0] TX_LAST       = 7'd47;
  localparam logic [BIT_W-1:0] RX_IDX_LAST   = 7'd6;
  localparam logic [BIT_W-1:0] RX_SHORT_LAST = 7'd31;
  localparam logic [BIT_W-1:0] RX_LONG_LAST  = 7'd119;
  localparam logic [BIT_W-1:0] RX_CRC_LAST   = 7'd7;

  localparam logic [6:0] IDX_NO_CRC  = 7'd63;
  localparam logic [7:0] CRC_SKIP    = 8'hff;

  typedef struct packed {
    logic        mode;
    logic [15:0] lead_clocks;
    logic [5:0]  cmd_index;
    logic [31:0] argument;
    logic [1:0]  response_kind;
    logic        cmd_line_in;
  } item_t;

  typedef struct packed {
    logic        clock_pulse;
    logic        cmd_drive;
    logic        cmd_out;
    logic        busy_res;
    logic        done_res;
    logic [31:0] response_word;
    logic [6:0]  response_index;
    logic        crc_error;
    logic        no_response;
  } result_t;

  typedef struct packed {
    logic [2:0]       phase;
    logic [15:0]      preclock_left;
    logic [BIT_W-1:0] bit_count;
    logic [39:0]      tx_shift;
    logic [6:0]       tx_crc;
    logic [1:0]       kind_held;
    logic [6:0]       rx_index;
    logic [31:0]      rx_word;
    logic [6:0]       rx_crc_calc;
    logic [7:0]       rx_crc_byte;
  } state_t;

  // One bit of CRC7 with polynomial x^7 + x^3 + 1.
  function automatic logic [6:0] crc7_step(input logic [6:0] c, input logic b);
    logic fb;
    fb = c[6] ^ b;
    return {c[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
  endfunction

endpackage

// ----- design/sdcl_if.sv -----
// Valid/ready channel interfaces for request/tick items and result items.
interface sdcl_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] lead_clocks;
  logic [5:0]  cmd_index;
  logic [31:0] argument;
  logic [1:0]  response_kind;
  logic        cmd_line_in;

  modport source(output valid, mode, lead_clocks, cmd_index, argument, response_kind,
                 cmd_line_in, input ready);
  modport sink(input valid, mode, lead_clocks, cmd_index, argument, response_kind,
               cmd_line_in, output ready);
endinterface

interface sdcl_out_if;
  logic        valid;
  logic        ready;
  logic        clock_pulse;
  logic        cmd_drive;
  logic        cmd_out;
  logic        busy_res;
  logic        done_res;
  logic [31:0] response_word;
  logic [6:0]  response_index;
  logic        crc_error;
  logic        no_response;

  modport source(output valid, clock_pulse, cmd_drive, cmd_out, busy_res, done_res,
                 response_word, response_index, crc_error, no_response, input ready);
  modport sink(input valid, clock_pulse, cmd_drive, cmd_out, busy_res, done_res,
               response_word, response_index, crc_error, no_response, output ready);
endinterface

// ----- design/sdcl_step.sv -----
// Next-state and result logic of the CMD-line engine for one request or tick.
module sdcl_step import sdcl_pkg::*; #(
  parameter int START_WAIT_LIMIT = START_WAIT_LIMIT_DEF,
  localparam int WaitW = $clog2(START_WAIT_LIMIT + 1)
) (
  input  state_t           st,
  input  logic [WaitW-1:0] wait_cnt,
  input  item_t            item,
  output state_t           st_nxt,
  output logic [WaitW-1:0] wait_nxt,
  output result_t          res
);

  localparam logic [WaitW-1:0] WaitLimit = WaitW'(START_WAIT_LIMIT);

  logic             b;
  logic [6:0]       idx_shift;
  logic [7:0]       crc_byte_shift;
  logic [WaitW-1:0] wait_inc;
  logic [BIT_W-1:0] data_last;

  always_comb begin
    st_nxt         = st;
    wait_nxt       = wait_cnt;
    res            = '0;
    b              = item.cmd_line_in;
    idx_shift      = {st.rx_index[5:0], b};
    crc_byte_shift = {st.rx_crc_byte[6:0], b};
    wait_inc       = wait_cnt + 1'b1;
    data_last      = (st.kind_held == KIND_LONG) ? RX_LONG_LAST : RX_SHORT_LAST;

    if (item.mode == MODE_REQ) begin
      // A request aborts whatever exchange is running.
      st_nxt.tx_shift      = {CMD_PREFIX, item.cmd_index, item.argument};
      st_nxt.tx_crc        = '0;
      st_nxt.kind_held     = item.response_kind;
      st_nxt.preclock_left = item.lead_clocks;
      st_nxt.bit_count     = '0;
      st_nxt.rx_index      = '0;
      st_nxt.rx_word       = '0;
      st_nxt.rx_crc_calc   = '0;
      st_nxt.rx_crc_byte   = '0;
      st_nxt.phase         = (item.lead_clocks != 16'd0) ? PH_PRE : PH_TX;
      wait_nxt             = '0;
      res.busy_res         = 1'b1;
    end else begin
      case (st.phase)
        PH_PRE: begin
          res.clock_pulse = 1'b1;
          res.busy_res    = 1'b1;
          if (st.preclock_left <= 16'd1) begin
            st_nxt.preclock_left = '0;
            st_nxt.phase         = PH_TX;
          end else begin
            st_nxt.preclock_left = st.preclock_left - 16'd1;
          end
        end
        PH_TX: begin
          res.clock_pulse = 1'b1;
          res.busy_res    = 1'b1;
          res.cmd_drive   = 1'b1;
          // The CRC is built up bit by bit while the first 40 bits go out,
          // then shifted out itself, followed by the end bit.
          if (st.bit_count < TX_FIELD_BITS) begin
            res.cmd_out     = st.tx_shift[39];
            st_nxt.tx_shift = {st.tx_shift[38:0], 1'b0};
            st_nxt.tx_crc   = crc7_step(st.tx_crc, st.tx_shift[39]);
          end else if (st.bit_count <= TX_CRC_LAST) begin
            res.cmd_out   = st.tx_crc[6];
            st_nxt.tx_crc = {st.tx_crc[5:0], 1'b0};
          end else begin
            res.cmd_out = 1'b1;
          end
          st_nxt.bit_count = st.bit_count + 1'b1;
          if (st.bit_count == TX_LAST) begin
            st_nxt.bit_count = '0;
            if (st.kind_held == KIND_SHORT || st.kind_held == KIND_LONG) begin
              wait_nxt     = '0;
              st_nxt.phase = PH_WAIT;
            end else begin
              res.done_res = 1'b1;
              st_nxt.phase = PH_IDLE;
            end
          end
        end
        PH_WAIT: begin
          res.clock_pulse = 1'b1;
          res.busy_res    = 1'b1;
          if (!b) begin
            st_nxt.bit_count   = '0;
            st_nxt.rx_index    = '0;
            st_nxt.rx_crc_calc = '0;
            st_nxt.phase       = PH_RXIDX;
          end else begin
            wait_nxt = wait_inc;
            if (wait_inc == WaitLimit) begin
              res.done_res    = 1'b1;
              res.no_response = 1'b1;
              st_nxt.phase    = PH_IDLE;
            end
          end
        end
        PH_RXIDX: begin
          res.clock_pulse    = 1'b1;
          res.busy_res       = 1'b1;
          st_nxt.rx_index    = idx_shift;
          st_nxt.rx_crc_calc = crc7_step(st.rx_crc_calc, b);
          st_nxt.bit_count   = st.bit_count + 1'b1;
          if (st.bit_count == RX_IDX_LAST) begin
            // Index 63 responses carry a CRC over the data only.
            if (idx_shift == IDX_NO_CRC) begin
              st_nxt.rx_crc_calc = '0;
            end
            st_nxt.bit_count = '0;
            st_nxt.rx_word   = '0;
            st_nxt.phase     = PH_RXDATA;
          end
        end
        PH_RXDATA: begin
          res.clock_pulse    = 1'b1;
          res.busy_res       = 1'b1;
          st_nxt.rx_word     = {st.rx_word[30:0], b};
          st_nxt.rx_crc_calc = crc7_step(st.rx_crc_calc, b);
          st_nxt.bit_count   = st.bit_count + 1'b1;
          if (st.bit_count == data_last) begin
            st_nxt.bit_count   = '0;
            st_nxt.rx_crc_byte = '0;
            st_nxt.phase       = PH_RXCRC;
          end
        end
        PH_RXCRC: begin
          res.clock_pulse    = 1'b1;
          res.busy_res       = 1'b1;
          st_nxt.rx_crc_byte = crc_byte_shift;
          st_nxt.bit_count   = st.bit_count + 1'b1;
          if (st.bit_count == RX_CRC_LAST) begin
            st_nxt.bit_count   = '0;
            res.done_res       = 1'b1;
            res.response_word  = st.rx_word;
            res.response_index = st.rx_index;
            res.crc_error      = !(st.rx_index == IDX_NO_CRC && crc_byte_shift == CRC_SKIP)
                                 && (crc_byte_shift[7:1] != st.rx_crc_calc);
            st_nxt.phase       = PH_IDLE;
          end
        end
        default: begin
          st_nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/sd_cmd_line_engine.sv -----
// SD host CMD-line engine: sends a command with CRC7 and receives the response.
// The result of an item is registered and valid in the cycle after its transfer.
// Throughput: one item per cycle unless the output stalls; the state register and
// the result register update in the same cycle, so the next item may follow at once.
// Reset: synchronous, active low; the engine returns to idle with no result pending.
module sd_cmd_line_engine import sdcl_pkg::*; #(
  parameter int START_WAIT_LIMIT = START_WAIT_LIMIT_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sdcl_in_if.sink   in_ch,
  sdcl_out_if.source out_ch
);

  localparam int WaitW = $clog2(START_WAIT_LIMIT + 1);

  state_t           state_r, state_nxt;
  logic [WaitW-1:0] wait_r, wait_nxt;
  result_t          res_r, res_nxt;
  logic             out_valid_r;
  logic             in_ready;
  logic             accept;
  item_t            item;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign item = '{mode:          in_ch.mode,
                  lead_clocks:   in_ch.lead_clocks,
                  cmd_index:     in_ch.cmd_index,
                  argument:      in_ch.argument,
                  response_kind: in_ch.response_kind,
                  cmd_line_in:   in_ch.cmd_line_in};

  sdcl_step #(
    .START_WAIT_LIMIT(START_WAIT_LIMIT)
  ) u_step (
    .st       (state_r),
    .wait_cnt (wait_r),
    .item     (item),
    .st_nxt   (state_nxt),
    .wait_nxt (wait_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.clock_pulse    = res_r.clock_pulse;
  assign out_ch.cmd_drive      = res_r.cmd_drive;
  assign out_ch.cmd_out        = res_r.cmd_out;
  assign out_ch.busy_res       = res_r.busy_res;
  assign out_ch.done_res       = res_r.done_res;
  assign out_ch.response_word  = res_r.response_word;
  assign out_ch.response_index = res_r.response_index;
  assign out_ch.crc_error      = res_r.crc_error;
  assign out_ch.no_response    = res_r.no_response;

`ifndef NO_ASSERTIONS
  a_req_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.mode == MODE_REQ |=> state_r.phase != PH_IDLE)
    else $error("request did not start an exchange");

  a_drive_clocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.cmd_drive |-> res_r.clock_pulse && res_r.busy_res)
    else $error("CMD driven without a card clock");

  a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.crc_error || res_r.no_response) |-> res_r.done_res)
    else $error("error status outside the final transfer");

  a_tx_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_TX |-> state_r.bit_count <= TX_LAST)
    else $error("command bit count out of range");
`endif

endmodule
